### rtl/mbr_pkg.sv
package mbr_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_W     = 7;

    typedef enum logic {
        MODE_READ   = 1'b0,
        MODE_REWIND = 1'b1
    } t_mode;

    typedef struct packed {
        logic [WORD_BITS-1:0] cur_word;
        logic [WORD_BITS-1:0] prev_word;
        logic [CNT_W-1:0]     bits_left;
        logic                 rewound;
    } t_state;

    typedef struct packed {
        t_mode                mode;
        logic [CNT_W-1:0]     count;
        logic [WORD_BITS-1:0] next_word;
    } t_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic                 word_taken;
        logic                 error;
    } t_result;

endpackage

### rtl/mbr_step.sv
module mbr_step
    import mbr_pkg::*;
(
    input  t_state  i_state,
    input  t_req    i_req,
    output t_state  o_state,
    output t_result o_result
);

    localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(WORD_BITS);

    logic [CNT_W-1:0]       cnt;
    logic [WORD_BITS-1:0]   cnt_mask;
    logic [WORD_BITS-1:0]   left_mask;
    logic [WORD_BITS-1:0]   fill_word;
    logic [2*WORD_BITS-1:0] window;
    logic [2*WORD_BITS-1:0] shifted;
    logic [CNT_W:0]         shamt;
    logic [CNT_W:0]         rew_sum;
    logic                   need_fill;

    always_comb begin
        cnt       = (i_req.count > WORD_CNT) ? WORD_CNT : i_req.count;
        // all ones when the width reaches a full word
        cnt_mask  = ~({WORD_BITS{1'b1}} << cnt);
        left_mask = ~({WORD_BITS{1'b1}} << i_state.bits_left);
        need_fill = (cnt > i_state.bits_left);
        fill_word = i_state.rewound ? i_state.prev_word : i_req.next_word;

        // funnel: unread bits of the current word on top, the refill word below
        window  = {i_state.cur_word & left_mask, fill_word};
        shamt   = {1'b0, i_state.bits_left} + (CNT_W+1)'(WORD_BITS) - {1'b0, cnt};
        shifted = window >> shamt;
        rew_sum = {1'b0, i_state.bits_left} + {1'b0, cnt};

        o_state  = i_state;
        o_result = '0;

        if (i_req.mode == MODE_READ) begin
            if (cnt == '0) begin
                o_result.error = 1'b1;
            end else begin
                o_result.data = shifted[WORD_BITS-1:0] & cnt_mask;
                if (need_fill) begin
                    o_state.prev_word   = i_state.cur_word;
                    o_state.cur_word    = fill_word;
                    o_state.rewound     = 1'b0;
                    o_result.word_taken = ~i_state.rewound;
                    o_state.bits_left   = CNT_W'(shamt);
                end else begin
                    o_state.bits_left = i_state.bits_left - cnt;
                end
            end
        end else begin
            if (rew_sum > (CNT_W+1)'(WORD_BITS)) begin
                if (i_state.rewound) begin
                    o_result.error = 1'b1;
                end else begin
                    o_state.bits_left = CNT_W'(rew_sum - (CNT_W+1)'(WORD_BITS));
                    o_state.rewound   = 1'b1;
                    o_state.cur_word  = i_state.prev_word;
                    o_state.prev_word = i_state.cur_word;
                end
            end else begin
                o_state.bits_left = CNT_W'(rew_sum);
            end
        end
    end

endmodule

### rtl/msb_first_bit_reader_with_rewind_core.sv
// Channel   Valid          Stall          Payload
// request   i_in_valid     o_in_stall     i_mode, i_count, i_next_word
// result    o_out_valid    i_out_stall    o_data, o_word_taken, o_error
//
// One request per cycle sustained while i_out_stall is low; each request passes
// the request register, then one 128-bit funnel shift into the result register.
// Synchronous active-low reset clears the word buffers, bit count and flags.
// A stalled result holds the pipe; a request waiting in the input register
// then raises o_in_stall until the result is taken.
module msb_first_bit_reader_with_rewind_core
    import mbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [WORD_BITS-1:0] i_next_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_BITS-1:0] o_data,
    output logic                 o_word_taken,
    output logic                 o_error
);

    logic    r_in_valid;
    t_req    r_req;
    t_state  r_state;
    logic    r_out_valid;
    t_result r_result;

    t_state  n_state;
    t_result n_result;
    logic    out_load;
    logic    in_load;

    assign out_load   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_in_valid & ~out_load;
    assign in_load    = i_in_valid & ~o_in_stall;

    mbr_step u_step (
        .i_state  (r_state),
        .i_req    (r_req),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (~o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (in_load) begin
            r_req.mode      <= t_mode'(i_mode);
            r_req.count     <= i_count;
            r_req.next_word <= i_next_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (out_load && r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (out_load && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data       = r_result.data;
    assign o_word_taken = r_result.word_taken;
    assign o_error      = r_result.error;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mbr_pkg::*;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode      = MODE_READ;
    logic [CNT_W-1:0]     i_count     = '0;
    logic [WORD_BITS-1:0] i_next_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [WORD_BITS-1:0] o_data;
    logic                 o_word_taken;
    logic                 o_error;

    msb_first_bit_reader_with_rewind_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_count      (i_count),
        .i_next_word  (i_next_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data       (o_data),
        .o_word_taken (o_word_taken),
        .o_error      (o_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow copy of the reader state
    logic [WORD_BITS-1:0] shadow_cur  = '0;
    logic [WORD_BITS-1:0] shadow_prev = '0;
    int unsigned          shadow_left = 0;
    bit                   shadow_rewound = 1'b0;

    t_result fields_due[$];
    int      mismatch_cnt = 0;
    bit      no_idle = 1'b0;

    function automatic logic [WORD_BITS-1:0] ones_below(input int unsigned n);
        if (n >= WORD_BITS) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic void swap_shadow();
        logic [WORD_BITS-1:0] t;
        t           = shadow_prev;
        shadow_prev = shadow_cur;
        shadow_cur  = t;
    endfunction

    function automatic t_result extract_field(input t_mode m, input logic [CNT_W-1:0] cnt,
                                              input logic [WORD_BITS-1:0] word);
        t_result              r;
        int unsigned          n;
        int unsigned          rest;
        logic [WORD_BITS-1:0] high;
        r = '0;
        n = (cnt > WORD_BITS) ? WORD_BITS : cnt;
        if (m == MODE_READ) begin
            if (n == 0) begin
                r.error = 1'b1;
            end else if (shadow_left >= n) begin
                r.data = (shadow_cur >> (shadow_left - n)) & ones_below(n);
                shadow_left -= n;
            end else begin
                rest = n - shadow_left;
                high = '0;
                if (shadow_left > 0)
                    high = (shadow_cur & ones_below(shadow_left)) << rest;
                if (shadow_rewound) begin
                    // swap back to the word we stepped out of
                    swap_shadow();
                    shadow_rewound = 1'b0;
                end else begin
                    shadow_prev  = shadow_cur;
                    shadow_cur   = word;
                    r.word_taken = 1'b1;
                end
                r.data = high | (shadow_cur >> (WORD_BITS - rest));
                shadow_left = WORD_BITS - rest;
            end
        end else begin
            if (shadow_left + n > WORD_BITS) begin
                if (shadow_rewound) begin
                    r.error = 1'b1;
                end else begin
                    shadow_left    = shadow_left + n - WORD_BITS;
                    shadow_rewound = 1'b1;
                    swap_shadow();
                end
            end else begin
                shadow_left += n;
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic send_req(input t_mode m, input logic [CNT_W-1:0] cnt,
                            input logic [WORD_BITS-1:0] word);
        while (!no_idle && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= m;
        i_count     <= cnt;
        i_next_word <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fields_due.push_back(extract_field(m, cnt, word));
    endtask

    // result side: check accepted results, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fields_due.size() == 0) begin
                flag_mismatch($sformatf("result with nothing due, data %h", o_data));
            end else begin
                t_result want;
                want = fields_due.pop_front();
                if (o_data !== want.data)
                    flag_mismatch($sformatf("data %h, want %h", o_data, want.data));
                if (o_word_taken !== want.word_taken)
                    flag_mismatch($sformatf("word_taken %b, want %b",
                                            o_word_taken, want.word_taken));
                if (o_error !== want.error)
                    flag_mismatch($sformatf("error %b, want %b", o_error, want.error));
            end
        end
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < 9);
    end

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h0000_0000_0000_0001;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_reads_from_reset();
        send_req(MODE_READ, 7'd64, 64'hDEAD_BEEF_0123_4567);   // first read refills
        send_req(MODE_READ, 7'd1, 64'h0);
        send_req(MODE_READ, 7'd63, 64'h0);
        send_req(MODE_READ, 7'd0, '1);                         // zero-length read
        send_req(MODE_READ, 7'd127, '1);                       // oversized, clamps to 64
        send_req(MODE_READ, 7'd5, 64'h8000_0000_0000_0000);
        send_req(MODE_READ, 7'd64, 64'h0123_4567_89AB_CDEF);   // straddles two words
        send_req(MODE_READ, 7'd60, 64'h0);
        send_req(MODE_READ, 7'd9, 64'hFEDC_BA98_7654_3210);
    endtask

    task automatic test_rewinds();
        send_req(MODE_REWIND, 7'd0, '1);
        send_req(MODE_REWIND, 7'd3, '1);
        send_req(MODE_REWIND, 7'd64, '1);                      // crosses into previous word
        send_req(MODE_REWIND, 7'd64, '1);                      // second crossing: error
        send_req(MODE_READ, 7'd20, 64'h5555_5555_5555_5555);
        send_req(MODE_READ, 7'd64, 64'hAAAA_AAAA_AAAA_AAAA);   // refill while rewound
        send_req(MODE_REWIND, 7'd127, '0);                     // oversized rewind
        send_req(MODE_READ, 7'd64, '0);
        send_req(MODE_READ, 7'd64, 64'h1234_5678_9ABC_DEF0);
        send_req(MODE_REWIND, 7'd100, '1);
        send_req(MODE_REWIND, 7'd1, '1);
        send_req(MODE_READ, 7'd33, 64'h0F0F_0F0F_0F0F_0F0F);
    endtask

    task automatic test_random_stream(input int n_items);
        t_mode            m;
        logic [CNT_W-1:0] cnt;
        int               kind;
        for (int i = 0; i < n_items; i++) begin
            no_idle = (i >= 400 && i < 560);
            kind = $urandom_range(0, 99);
            if (kind < 62) begin
                m = MODE_READ;
                case ($urandom_range(0, 3))
                    0:       cnt = 7'($urandom_range(1, 8));
                    1:       cnt = 7'($urandom_range(56, 64));
                    default: cnt = 7'($urandom_range(1, 64));
                endcase
            end else if (kind < 88) begin
                m = MODE_REWIND;
                cnt = 7'($urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 16));
            end else if (kind < 94) begin
                m = MODE_READ;
                cnt = $urandom_range(0, 3) == 0 ? 7'd0 : 7'($urandom_range(65, 127));
            end else begin
                m = MODE_REWIND;
                cnt = 7'($urandom_range(65, 127));
            end
            send_req(m, cnt, pick_word());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reads_from_reset();
        test_rewinds();
        test_random_stream(950);
        i_in_valid <= 1'b0;
        while (fields_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("** msb_first_bit_reader_with_rewind_core: PASSED **");
        end else begin
            $display("** msb_first_bit_reader_with_rewind_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout, %0d results still due", fields_due.size());
        $display("** msb_first_bit_reader_with_rewind_core: FAILED **");
        $finish;
    end

endmodule
